// File: rtl/f32asmd_pkg.sv
package f32asmd_pkg;

	localparam int ExpBias = 127;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	// signed working exponent, wide enough for every intermediate value
	typedef logic signed [10:0] exp_t;

endpackage

// File: rtl/f32asmd_if.sv
interface f32asmd_req_if;
	import f32asmd_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] req_type;
	logic [31:0] operand_a;
	logic [31:0] operand_b;
	modport source (output valid, req_type, operand_a, operand_b, input ready);
	modport sink (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface f32asmd_rsp_if;
	logic valid;
	logic ready;
	logic [31:0] result_word;
	logic exponent_range_error;
	modport source (output valid, result_word, exponent_range_error, input ready);
	modport sink (input valid, result_word, exponent_range_error, output ready);
endinterface

// File: rtl/f32asmd_seq.sv
// One shared add/subtract unit over a 48-bit accumulator, stepped by a sequencer:
// multiply runs 24 shift-add steps, divide 25 restoring steps, alignment and
// normalization one bit per cycle.
module f32asmd_seq
	import f32asmd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	f32asmd_req_if.sink req,
	f32asmd_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALIGN,
		ST_ADDSUB,
		ST_MUL,
		ST_DIV,
		ST_NORM,
		ST_PACK,
		ST_OUT
	} state_t;

	state_t state_q;
	op_t op_q;
	logic sign_q;
	logic eff_sub_q;
	exp_t exp_q;
	logic [7:0] dist_q;
	logic [4:0] cnt_q;
	logic [47:0] acc_q;   // product / remainder / sum
	logic [24:0] m1_q;    // multiplicand / divisor / big mantissa
	logic [23:0] m2_q;    // multiplier / small mantissa
	logic [24:0] quo_q;
	logic zero_q;
	logic [31:0] word_q;
	logic flag_q;

	// operand fields
	logic sa, sb, sbe;
	logic [7:0] ea, eb;
	logic [23:0] ma, mb;
	logic a_big;
	assign sa = req.operand_a[31];
	assign sb = req.operand_b[31];
	assign sbe = sb ^ req.req_type[0];
	assign ea = req.operand_a[30:23];
	assign eb = req.operand_b[30:23];
	assign ma = {1'b1, req.operand_a[22:0]};
	assign mb = {1'b1, req.operand_b[22:0]};
	assign a_big = (ea > eb) || ((ea == eb) && (ma >= mb));

	// shared adder: operands and add/subtract chosen by state
	logic [48:0] add_a, add_b, add_y;
	logic add_sub;
	always_comb begin
		add_a = {1'b0, acc_q};
		add_b = '0;
		add_sub = 1'b0;
		unique case (state_q)
			ST_MUL: begin
				add_a = {1'b0, acc_q};
				add_b = m2_q[cnt_q] ? {1'b0, m1_q[23:0], 24'd0} : '0;
			end
			ST_DIV: begin
				add_a = {1'b0, acc_q};
				add_b = {24'd0, m1_q};
				add_sub = 1'b1;
			end
			ST_ADDSUB: begin
				add_a = {25'd0, m1_q[23:0]};
				add_b = {25'd0, m2_q};
				add_sub = eff_sub_q;
			end
			default: begin
				add_b = '0;
			end
		endcase
		add_y = add_sub ? (add_a - add_b) : (add_a + add_b);
	end

	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = (state_q == ST_OUT);
	assign rsp.result_word = word_q;
	assign rsp.exponent_range_error = flag_q;

	exp_t e_fin;
	assign e_fin = exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q <= OP_ADD;
			sign_q <= 1'b0;
			eff_sub_q <= 1'b0;
			exp_q <= '0;
			dist_q <= '0;
			cnt_q <= '0;
			acc_q <= '0;
			m1_q <= '0;
			m2_q <= '0;
			quo_q <= '0;
			zero_q <= 1'b0;
			word_q <= '0;
			flag_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						op_q <= op_t'(req.req_type);
						zero_q <= 1'b0;
						cnt_q <= '0;
						quo_q <= '0;
						unique case (op_t'(req.req_type))
							OP_MUL: begin
								sign_q <= sa ^ sb;
								exp_q <= exp_t'({3'd0, ea}) + exp_t'({3'd0, eb})
									- exp_t'(ExpBias);
								acc_q <= '0;
								m1_q <= {1'b0, ma};
								m2_q <= mb;
								state_q <= ST_MUL;
							end
							OP_DIV: begin
								sign_q <= sa ^ sb;
								exp_q <= exp_t'({3'd0, ea}) - exp_t'({3'd0, eb})
									+ exp_t'(ExpBias);
								// remainder starts at ma, divisor mb
								acc_q <= {24'd0, ma};
								m1_q <= {1'b0, mb};
								cnt_q <= 5'd24;
								state_q <= ST_DIV;
							end
							default: begin
								eff_sub_q <= sa ^ sbe;
								if (a_big) begin
									sign_q <= sa;
									exp_q <= exp_t'({3'd0, ea});
									dist_q <= ea - eb;
									m1_q <= {1'b0, ma};
									m2_q <= mb;
								end else begin
									sign_q <= sbe;
									exp_q <= exp_t'({3'd0, eb});
									dist_q <= eb - ea;
									m1_q <= {1'b0, mb};
									m2_q <= ma;
								end
								state_q <= ST_ALIGN;
							end
						endcase
					end
				end
				ST_ALIGN: begin
					// shift small mantissa one bit per cycle
					if (dist_q == 8'd0 || m2_q == '0) begin
						state_q <= ST_ADDSUB;
					end else begin
						m2_q <= m2_q >> 1;
						dist_q <= dist_q - 8'd1;
					end
				end
				ST_ADDSUB: begin
					acc_q <= add_y[47:0];
					if (eff_sub_q && add_y[23:0] == 24'd0) zero_q <= 1'b1;
					state_q <= ST_NORM;
				end
				ST_MUL: begin
					acc_q <= add_y[48:1];
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd23) state_q <= ST_NORM;
				end
				ST_DIV: begin
					// restoring step: remainder compare/subtract, then shift
					if (!add_y[48]) begin
						acc_q <= {add_y[46:0], 1'b0};
						quo_q <= {quo_q[23:0], 1'b1};
					end else begin
						acc_q <= {acc_q[46:0], 1'b0};
						quo_q <= {quo_q[23:0], 1'b0};
					end
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= ST_NORM;
				end
				ST_NORM: begin
					unique case (op_q)
						OP_MUL: begin
							if (acc_q[47]) begin
								acc_q <= {1'b0, acc_q[47:1]};
								exp_q <= exp_q + exp_t'(1);
							end
							state_q <= ST_PACK;
						end
						OP_DIV: begin
							if (quo_q[24]) quo_q <= {1'b0, quo_q[24:1]};
							else exp_q <= exp_q - exp_t'(1);
							state_q <= ST_PACK;
						end
						default: begin
							if (zero_q) begin
								state_q <= ST_PACK;
							end else if (acc_q[24]) begin
								acc_q <= {1'b0, acc_q[47:1]};
								exp_q <= exp_q + exp_t'(1);
								state_q <= ST_PACK;
							end else if (!acc_q[23]) begin
								acc_q <= {acc_q[46:0], 1'b0};
								exp_q <= exp_q - exp_t'(1);
							end else begin
								state_q <= ST_PACK;
							end
						end
					endcase
				end
				ST_PACK: begin
					if (zero_q) begin
						word_q <= '0;
						flag_q <= 1'b0;
					end else begin
						flag_q <= (e_fin < exp_t'(1)) || (e_fin > exp_t'(254));
						unique case (op_q)
							OP_MUL: word_q <= {sign_q, e_fin[7:0], acc_q[45:23]};
							OP_DIV: word_q <= {sign_q, e_fin[7:0], quo_q[22:0]};
							default: word_q <= {sign_q, e_fin[7:0], acc_q[22:0]};
						endcase
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (rsp.ready) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("ready while result pending");
	a_out_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(word_q))
		else $error("result dropped");
	a_mul_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |-> cnt_q <= 5'd23) else $error("mul count overrun");
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && zero_q |-> word_q == 32'd0 && !flag_q)
		else $error("cancel result not zero");
`endif

endmodule

// File: rtl/float32_add_sub_mul_div.sv
// Truncating single-precision add, subtract, multiply and divide. One transaction
// at a time: a request is taken when ready is high, and ready stays low until the
// result transaction is taken. The work is done by one shared adder stepped by a
// sequencer: multiply runs 24 shift-add steps, divide 25 restoring steps, and
// add/subtract aligns and normalizes one bit per cycle, at most 24 alignment bits
// and 23 normalization bits. Out-of-range exponents set exponent_range_error
// and wrap.
module float32_add_sub_mul_div
	import f32asmd_pkg::*;
(
	input logic clk,
	input logic arst_n,
	f32asmd_req_if.sink req,
	f32asmd_rsp_if.source rsp
);

	f32asmd_seq u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

endmodule
